// ===== src/e2c_pkg.sv =====
// e2c_pkg: types, constants and calendar helpers of the epoch-seconds to calendar block.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package e2c_pkg;

   localparam int EpochBits = 32;
   localparam int DayBits   = 16;
   localparam int SecShift  = 37;
   localparam int HourShift = 36;
   localparam int WdayShift = 19;

   localparam logic [7:0] EPOCH_YEAR_OFS = 8'd70;
   localparam logic [2:0] EPOCH_WEEKDAY  = 3'd4;
   localparam logic [3:0] LAST_MONTH     = 4'd11;
   localparam logic       DIV_LAST_PHASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_SEC,
      ST_DIV_MIN,
      ST_DIV_HOUR,
      ST_DIV_WDAY,
      ST_YEAR,
      ST_MONTH,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      DIV_SEC,
      DIV_MIN,
      DIV_HOUR,
      DIV_WDAY
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      div_sel_type div_sel;
      logic        year_step;
      logic        month_step;
      logic        capture;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic year_done;
      logic month_done;
   } status_type;

   typedef struct packed {
      logic [5:0] second_of_minute;
      logic [5:0] minute_of_hour;
      logic [4:0] hour_of_day;
      logic [2:0] weekday;
      logic [8:0] day_of_year;
      logic [7:0] years_since_1900;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
   } result_type;

   function automatic logic [5:0] divisor(div_sel_type sel);
      logic [5:0] d;
      unique case (sel)
         DIV_SEC:  d = 6'd60;
         DIV_MIN:  d = 6'd60;
         DIV_HOUR: d = 6'd24;
         DIV_WDAY: d = 6'd7;
         default:  d = 6'd60;
      endcase
      return d;
   endfunction

   // Reciprocals: 60 and 24 are exact over 32-bit dividends, 7 over the 16-bit day count.
   function automatic logic [EpochBits-1:0] div_magic(div_sel_type sel);
      logic [EpochBits-1:0] m;
      unique case (sel)
         DIV_SEC:  m = 32'h8888_8889;
         DIV_MIN:  m = 32'h8888_8889;
         DIV_HOUR: m = 32'hAAAA_AAAB;
         DIV_WDAY: m = 32'd74899;
         default:  m = 32'h8888_8889;
      endcase
      return m;
   endfunction

   // Year is ofs + 1900; 1900 is a multiple of 4, and within 1900..2155 the
   // century years are offsets 0, 100 and 200, of which only 100 (2000) is leap.
   function automatic logic is_leap(logic [7:0] ofs);
      return (ofs[1:0] == 2'd0) && (ofs != 8'd0) && (ofs != 8'd200);
   endfunction

   function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
      logic [4:0] len;
      case (m) inside
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         4'd1:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== src/e2c_if.sv =====
// e2c_req_if / e2c_rsp_if: valid-ready channels of the calendar block.
// Depends on e2c_pkg for nothing but follows its field widths.
`timescale 1ns / 1ps

interface e2c_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] second_of_minute;
   logic [5:0] minute_of_hour;
   logic [4:0] hour_of_day;
   logic [2:0] weekday;
   logic [8:0] day_of_year;
   logic [7:0] years_since_1900;
   logic [3:0] month_index;
   logic [4:0] day_of_month;

   modport source (output valid, output second_of_minute, output minute_of_hour,
                   output hour_of_day, output weekday, output day_of_year,
                   output years_since_1900, output month_index, output day_of_month,
                   input ready);
   modport sink   (input valid, input second_of_minute, input minute_of_hour,
                   input hour_of_day, input weekday, input day_of_year,
                   input years_since_1900, input month_index, input day_of_month,
                   output ready);
endinterface

// ===== src/epoch_seconds_to_calendar_top.sv =====
// Sequence: accept, then the seconds, minutes, hours and weekday divisions, each a
// multiply phase and a shift phase, then the year loop, the month loop and one capture.
// One conversion runs at a time: a new request is taken only once the last is captured.
// A finished beat waits in the output register while the next request is taken, and a
// new capture waits until that beat is taken. Reset (synchronous) returns the
// sequencer to idle and drops the response valid.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top
   import e2c_pkg::*;
(
   input logic   clock,
   input logic   reset,
   e2c_req_if.sink   req_chan,
   e2c_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   result_type result;

   e2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   e2c_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .epoch_seconds (req_chan.epoch_seconds),
      .cmd           (cmd),
      .status        (status),
      .result        (result)
   );

   assign rsp_chan.second_of_minute = result.second_of_minute;
   assign rsp_chan.minute_of_hour   = result.minute_of_hour;
   assign rsp_chan.hour_of_day      = result.hour_of_day;
   assign rsp_chan.weekday          = result.weekday;
   assign rsp_chan.day_of_year      = result.day_of_year;
   assign rsp_chan.years_since_1900 = result.years_since_1900;
   assign rsp_chan.month_index      = result.month_index;
   assign rsp_chan.day_of_month     = result.day_of_month;

endmodule

// ===== src/e2c_datapath.sv =====
// e2c_datapath: shared reciprocal-multiply constant divider, year and month subtractors,
// result register. Depends on e2c_pkg; driven by e2c_ctrl commands.
`timescale 1ns / 1ps

module e2c_datapath
   import e2c_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [EpochBits-1:0] epoch_seconds,
   input  cmd_type              cmd,
   output status_type           status,
   output result_type           result
);

   logic [EpochBits-1:0]   quot_ff, quot_in;
   logic [2*EpochBits-1:0] prod_ff, prod_in;
   logic                   phase_ff, phase_in;
   logic [5:0]             sec_ff, sec_in;
   logic [5:0]             min_ff, min_in;
   logic [4:0]             hour_ff, hour_in;
   logic [2:0]             wday_ff, wday_in;
   logic [DayBits-1:0]     day_ff, day_in;
   logic [8:0]             yday_ff, yday_in;
   logic [7:0]             year_ff, year_in;
   logic [3:0]             month_ff, month_in;
   result_type             result_ff, result_in;

   logic [5:0]             div_d;
   logic [EpochBits-1:0]   div_m;
   logic [2*EpochBits-1:0] div_prod;
   logic [EpochBits-1:0]   div_q;
   logic [7:0]             div_qd;
   logic [7:0]             div_r;
   logic                   leap;
   logic [8:0]             ylen;
   logic [4:0]             mlen;
   logic                   div_last;
   logic                   year_done;
   logic                   month_done;

   always_comb begin
      div_d    = divisor(cmd.div_sel);
      div_m    = div_magic(cmd.div_sel);
      div_prod = {{EpochBits{1'b0}}, quot_ff} * {{EpochBits{1'b0}}, div_m};
      unique case (cmd.div_sel)
         DIV_SEC:  div_q = EpochBits'(prod_ff >> SecShift);
         DIV_MIN:  div_q = EpochBits'(prod_ff >> SecShift);
         DIV_HOUR: div_q = EpochBits'(prod_ff >> HourShift);
         DIV_WDAY: div_q = EpochBits'(prod_ff >> WdayShift);
         default:  div_q = EpochBits'(prod_ff >> SecShift);
      endcase
      div_qd     = 8'(div_q[7:0] * {2'b00, div_d});
      div_r      = quot_ff[7:0] - div_qd;
      leap       = is_leap(year_ff);
      ylen       = leap ? 9'd366 : 9'd365;
      mlen       = month_days(month_ff, leap);
      div_last   = phase_ff == DIV_LAST_PHASE;
      year_done  = day_ff < {{(DayBits-9){1'b0}}, ylen};
      month_done = (day_ff < {{(DayBits-5){1'b0}}, mlen}) || (month_ff >= LAST_MONTH);
   end

   always_comb begin
      quot_in   = quot_ff;
      prod_in   = prod_ff;
      phase_in  = phase_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hour_in   = hour_ff;
      wday_in   = wday_ff;
      day_in    = day_ff;
      yday_in   = yday_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      result_in = result_ff;
      if (cmd.load) begin
         quot_in  = epoch_seconds;
         phase_in = 1'b0;
         year_in  = EPOCH_YEAR_OFS;
         month_in = 4'd0;
      end
      if (cmd.div_step) begin
         phase_in = ~phase_ff;
         if (!div_last) begin
            prod_in = div_prod;
         end else begin
            quot_in = div_q;
            unique case (cmd.div_sel)
               DIV_SEC:  sec_in  = div_r[5:0];
               DIV_MIN:  min_in  = div_r[5:0];
               DIV_HOUR: begin
                  hour_in = div_r[4:0];
                  day_in  = div_q[DayBits-1:0];
                  quot_in = div_q + EpochBits'(EPOCH_WEEKDAY);
               end
               DIV_WDAY: wday_in = div_r[2:0];
               default:  sec_in  = div_r[5:0];
            endcase
         end
      end
      if (cmd.year_step) begin
         if (year_done) begin
            yday_in = day_ff[8:0];
         end else begin
            day_in  = day_ff - {{(DayBits-9){1'b0}}, ylen};
            year_in = year_ff + 8'd1;
         end
      end
      if (cmd.month_step && !month_done) begin
         day_in   = day_ff - {{(DayBits-5){1'b0}}, mlen};
         month_in = month_ff + 4'd1;
      end
      if (cmd.capture) begin
         result_in.second_of_minute = sec_ff;
         result_in.minute_of_hour   = min_ff;
         result_in.hour_of_day      = hour_ff;
         result_in.weekday          = wday_ff;
         result_in.day_of_year      = yday_ff;
         result_in.years_since_1900 = year_ff;
         result_in.month_index      = month_ff;
         result_in.day_of_month     = day_ff[4:0] + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff   <= quot_in;
      prod_ff   <= prod_in;
      sec_ff    <= sec_in;
      min_ff    <= min_in;
      hour_ff   <= hour_in;
      wday_ff   <= wday_in;
      day_ff    <= day_in;
      yday_ff   <= yday_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      result_ff <= result_in;
   end

   assign status.div_last   = div_last;
   assign status.year_done  = year_done;
   assign status.month_done = month_done;
   assign result            = result_ff;

endmodule

// ===== src/e2c_ctrl.sv =====
// e2c_ctrl: sequencer of the calendar block; steps the divider, year and month
// loops and owns the response valid. Depends on e2c_pkg.
`timescale 1ns / 1ps

module e2c_ctrl
   import e2c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV_SEC;
            end
         end
         ST_DIV_SEC: begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = DIV_SEC;
            if (status.div_last) state_in = ST_DIV_MIN;
         end
         ST_DIV_MIN: begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = DIV_MIN;
            if (status.div_last) state_in = ST_DIV_HOUR;
         end
         ST_DIV_HOUR: begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = DIV_HOUR;
            if (status.div_last) state_in = ST_DIV_WDAY;
         end
         ST_DIV_WDAY: begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = DIV_WDAY;
            if (status.div_last) state_in = ST_YEAR;
         end
         ST_YEAR: begin
            cmd.year_step = 1'b1;
            if (status.year_done) state_in = ST_MONTH;
         end
         ST_MONTH: begin
            cmd.month_step = 1'b1;
            if (status.month_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/e2c_checker.sv =====
// e2c_checker: port-level assertions of the calendar block, bound to the top level.
// Depends on the top level's channel ports only.
`timescale 1ns / 1ps

module e2c_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] second_of_minute,
   input logic [5:0] minute_of_hour,
   input logic [4:0] hour_of_day,
   input logic [2:0] weekday,
   input logic [8:0] day_of_year,
   input logic [7:0] years_since_1900,
   input logic [3:0] month_index,
   input logic [4:0] day_of_month
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(second_of_minute)
         && $stable(day_of_month) && $stable(month_index) && $stable(years_since_1900))
      else $error("stalled response beat changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a conversion runs");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> second_of_minute < 6'd60 && minute_of_hour < 6'd60
         && hour_of_day < 5'd24 && weekday < 3'd7)
      else $error("time of day out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> month_index < 4'd12 && day_of_month != 5'd0
         && years_since_1900 >= 8'd70 && years_since_1900 <= 8'd206
         && day_of_year <= 9'd365)
      else $error("date out of range");

   a_january_yday: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && month_index == 4'd0 |-> day_of_year == {4'd0, day_of_month - 5'd1})
      else $error("january day of year mismatch");

endmodule

bind epoch_seconds_to_calendar_top e2c_checker u_e2c_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .second_of_minute (rsp_chan.second_of_minute),
   .minute_of_hour   (rsp_chan.minute_of_hour),
   .hour_of_day      (rsp_chan.hour_of_day),
   .weekday          (rsp_chan.weekday),
   .day_of_year      (rsp_chan.day_of_year),
   .years_since_1900 (rsp_chan.years_since_1900),
   .month_index      (rsp_chan.month_index),
   .day_of_month     (rsp_chan.day_of_month)
);
